// ----- hw/rtl/fcm_pkg.sv -----
package fcm_pkg;

    localparam int NUM_LANES = 8;
    localparam int DIST_W    = 24;
    localparam int MEMB_W    = 17;
    localparam int RECIP_W   = 41;
    localparam int SUM_W     = 44;
    localparam int NUM_W     = RECIP_W + 16;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;

    localparam logic [MEMB_W-1:0] ONE_Q16 = 17'h10000;

    // register indexes on the config port
    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [MEMB_W-1:0]  memb_t;

    typedef struct packed {
        dist_t distance_0;
        dist_t distance_1;
        dist_t distance_2;
        dist_t distance_3;
        dist_t distance_4;
        dist_t distance_5;
        dist_t distance_6;
        dist_t distance_7;
    } dist_in_t;

    typedef struct packed {
        memb_t             membership_0;
        memb_t             membership_1;
        memb_t             membership_2;
        memb_t             membership_3;
        memb_t             membership_4;
        memb_t             membership_5;
        memb_t             membership_6;
        memb_t             membership_7;
        logic              exact_match;
        logic [IDX_W-1:0]  matched_class;
    } memb_out_t;

    // per-pixel control that rides along the pipeline
    typedef struct packed {
        logic                 match;
        logic [IDX_W-1:0]     idx;
        logic [NUM_LANES-1:0] mask;
    } side_t;

endpackage

// ----- hw/rtl/fcm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, LANES in parallel.
// Caller guarantees rem_in < den_in; quotient appears in quo_out after QW stages.
module fcm_div #(
    parameter int LANES = 8,
    parameter int DW    = 24,
    parameter int QW    = 41,
    parameter int SW    = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] rem_in  [LANES],
    input  logic [QW-1:0] low_in  [LANES],
    input  logic [DW-1:0] den_in  [LANES],
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo_out [LANES],
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [QW][LANES];
    logic [QW-1:0] low_reg  [QW][LANES];
    logic [DW-1:0] den_reg  [QW][LANES];
    logic [SW-1:0] side_reg [QW];
    logic          valid_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_c  [LANES];
        logic [QW-1:0] low_c  [LANES];
        logic [DW-1:0] den_c  [LANES];
        logic [SW-1:0] side_c;
        logic          valid_c;
        logic [DW-1:0] rem_next [LANES];
        logic [QW-1:0] low_next [LANES];

        if (k == 0) begin : g_first
            assign rem_c   = rem_in;
            assign low_c   = low_in;
            assign den_c   = den_in;
            assign side_c  = side_in;
            assign valid_c = in_valid;
        end else begin : g_rest
            assign rem_c   = rem_reg[k-1];
            assign low_c   = low_reg[k-1];
            assign den_c   = den_reg[k-1];
            assign side_c  = side_reg[k-1];
            assign valid_c = valid_reg[k-1];
        end

        always_comb
        begin
            logic [DW:0] trial;
            logic        ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_c[l], low_c[l][QW-1]};
                ge    = (trial >= {1'b0, den_c[l]});
                rem_next[l] = ge ? DW'(trial - {1'b0, den_c[l]}) : trial[DW-1:0];
                low_next[l] = {low_c[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= valid_c;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            low_reg[k]  <= low_next;
            den_reg[k]  <= den_c;
            side_reg[k] <= side_c;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo_out   = low_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// ----- hw/rtl/fcm_sum.sv -----
// Three-level registered adder tree over the active reciprocals.
module fcm_sum import fcm_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  recip_t recip_in [NUM_LANES],
    input  side_t  side_in,
    output logic   out_valid,
    output sum_t   sum_out,
    output recip_t recip_out [NUM_LANES],
    output side_t  side_out
);

    logic [RECIP_W:0]   l1_reg [4];
    logic [RECIP_W+1:0] l2_reg [2];
    sum_t               l3_reg;
    recip_t             r1_reg [NUM_LANES];
    recip_t             r2_reg [NUM_LANES];
    recip_t             r3_reg [NUM_LANES];
    side_t              s1_reg, s2_reg, s3_reg;
    logic [2:0]         valid_reg;

    recip_t masked [NUM_LANES];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
            masked[l] = side_in.mask[l] ? recip_in[l] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
            l1_reg[j] <= {1'b0, masked[2*j]} + {1'b0, masked[2*j+1]};
        for (int j = 0; j < 2; j++)
            l2_reg[j] <= {1'b0, l1_reg[2*j]} + {1'b0, l1_reg[2*j+1]};
        l3_reg <= {1'b0, l2_reg[0]} + {1'b0, l2_reg[1]};
        r1_reg <= recip_in;
        r2_reg <= r1_reg;
        r3_reg <= r2_reg;
        s1_reg <= side_in;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
    end

    assign out_valid = valid_reg[2];
    assign sum_out   = l3_reg;
    assign recip_out = r3_reg;
    assign side_out  = s3_reg;

endmodule

// ----- hw/rtl/fuzzy_cmeans_membership_top.sv -----
// Throughput: one pixel per cycle; busy is always low.
// Path: input register, 41-stage reciprocal divider, 3-stage adder tree,
// numerator add, 17-stage normalizing divider, output register.
// Reset clears the valid pipeline and sets the two config registers to 3 and 1.
// The receiver cannot stall; results must be taken on the done cycle.
module fuzzy_cmeans_membership_top import fcm_pkg::*; #(
    parameter int MAX_CLASSES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dist_in_t          distances,
    output logic              done,
    output memb_out_t         result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DIST_W-1:0] cfg_data
);

    localparam int LATENCY = 64;
    localparam int SIDE_W  = $bits(side_t);

    logic [CNT_W-1:0] active_reg;
    dist_t            limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 4'd3;
            limit_reg  <= 24'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE: active_reg <= cfg_data[CNT_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage: class mask, near-zero match, zero distance treated as one
    dist_t             d_in [NUM_LANES];
    logic [CNT_W-1:0]  n_eff;
    side_t             side_c;

    assign d_in[0] = distances.distance_0;
    assign d_in[1] = distances.distance_1;
    assign d_in[2] = distances.distance_2;
    assign d_in[3] = distances.distance_3;
    assign d_in[4] = distances.distance_4;
    assign d_in[5] = distances.distance_5;
    assign d_in[6] = distances.distance_6;
    assign d_in[7] = distances.distance_7;

    always_comb
    begin
        if (active_reg == '0)
            n_eff = CNT_W'(1);
        else if (active_reg > CNT_W'(MAX_CLASSES))
            n_eff = CNT_W'(MAX_CLASSES);
        else
            n_eff = active_reg;
        side_c.match = 1'b0;
        side_c.idx   = '0;
        for (int i = 0; i < NUM_LANES; i++)
            side_c.mask[i] = (CNT_W'(i) < n_eff);
        // scan downward so the lowest matching class wins
        for (int i = NUM_LANES - 1; i >= 0; i--)
        begin
            if (side_c.mask[i] && (d_in[i] < limit_reg))
            begin
                side_c.match = 1'b1;
                side_c.idx   = IDX_W'(i);
            end
        end
    end

    logic   s0_valid_reg;
    dist_t  s0_d_reg [NUM_LANES];
    side_t  s0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
            s0_d_reg[i] <= (d_in[i] == '0) ? DIST_W'(1) : d_in[i];
        s0_side_reg <= side_c;
    end

    // reciprocal: 2^40 / d
    dist_t              rc_rem_in [NUM_LANES];
    recip_t             rc_low_in [NUM_LANES];
    recip_t             rc_quo    [NUM_LANES];
    logic               rc_valid;
    logic [SIDE_W-1:0]  rc_side;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            rc_rem_in[i] = '0;
            rc_low_in[i] = {1'b1, {(RECIP_W-1){1'b0}}};
        end
    end

    fcm_div #(
        .LANES (NUM_LANES),
        .DW    (DIST_W),
        .QW    (RECIP_W),
        .SW    (SIDE_W)
    ) u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .rem_in    (rc_rem_in),
        .low_in    (rc_low_in),
        .den_in    (s0_d_reg),
        .side_in   (s0_side_reg),
        .out_valid (rc_valid),
        .quo_out   (rc_quo),
        .side_out  (rc_side)
    );

    logic   sm_valid;
    sum_t   sm_sum;
    recip_t sm_recip [NUM_LANES];
    side_t  sm_side;

    fcm_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rc_valid),
        .recip_in  (rc_quo),
        .side_in   (side_t'(rc_side)),
        .out_valid (sm_valid),
        .sum_out   (sm_sum),
        .recip_out (sm_recip),
        .side_out  (sm_side)
    );

    // numerator r * 2^16 + S / 2
    logic   pa_valid_reg;
    num_t   pa_num_reg [NUM_LANES];
    sum_t   pa_sum_reg;
    side_t  pa_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pa_valid_reg <= 1'b0;
        else
            pa_valid_reg <= sm_valid;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
            pa_num_reg[i] <= {sm_recip[i], 16'b0} + NUM_W'(sm_sum >> 1);
        pa_sum_reg  <= sm_sum;
        pa_side_reg <= sm_side;
    end

    // normalize: quotient never exceeds 2^16, so 17 quotient bits suffice
    sum_t               nd_rem_in [NUM_LANES];
    memb_t              nd_low_in [NUM_LANES];
    sum_t               nd_den_in [NUM_LANES];
    memb_t              nd_quo    [NUM_LANES];
    logic               nd_valid;
    logic [SIDE_W-1:0]  nd_side;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            nd_rem_in[i] = SUM_W'(pa_num_reg[i][NUM_W-1:MEMB_W]);
            nd_low_in[i] = pa_num_reg[i][MEMB_W-1:0];
            nd_den_in[i] = pa_sum_reg;
        end
    end

    fcm_div #(
        .LANES (NUM_LANES),
        .DW    (SUM_W),
        .QW    (MEMB_W),
        .SW    (SIDE_W)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pa_valid_reg),
        .rem_in    (nd_rem_in),
        .low_in    (nd_low_in),
        .den_in    (nd_den_in),
        .side_in   (pa_side_reg),
        .out_valid (nd_valid),
        .quo_out   (nd_quo),
        .side_out  (nd_side)
    );

    side_t      out_side;
    memb_t      memb [NUM_LANES];
    logic       done_reg;
    memb_out_t  result_reg;

    assign out_side = side_t'(nd_side);

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (out_side.match)
                memb[i] = (out_side.idx == IDX_W'(i)) ? ONE_Q16 : '0;
            else if (!out_side.mask[i])
                memb[i] = '0;
            else if (nd_quo[i] > ONE_Q16)
                memb[i] = ONE_Q16;
            else
                memb[i] = nd_quo[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= nd_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg.membership_0  <= memb[0];
        result_reg.membership_1  <= memb[1];
        result_reg.membership_2  <= memb[2];
        result_reg.membership_3  <= memb[3];
        result_reg.membership_4  <= memb[4];
        result_reg.membership_5  <= memb[5];
        result_reg.membership_6  <= memb[6];
        result_reg.membership_7  <= memb[7];
        result_reg.exact_match   <= out_side.match;
        result_reg.matched_class <= out_side.match ? out_side.idx : '0;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("transfer did not complete after pipeline latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching start");

    a_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.exact_match |-> result.matched_class == '0)
        else $error("matched_class set without exact match");

endmodule
